@@ design/dteq_pkg.sv @@
`default_nettype none

package dteq_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int RANK_W    = SLOT_W;
  localparam int TYPE_W    = 3;
  localparam int KIND_W    = 2;
  localparam int DELAY_W   = 32;
  localparam int ARG_W     = 32;
  localparam int REM_W     = 31;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ARM    = 3'd0,
    REQ_DISARM = 3'd1,
    REQ_QUERY  = 3'd2,
    REQ_REARM  = 3'd3,
    REQ_TICK   = 3'd4
  } req_type_t;

  typedef enum logic [KIND_W-1:0] {
    RES_FIRED     = 2'd0,
    RES_QUERY     = 2'd1,
    RES_DONE      = 2'd2,
    RES_NOT_ARMED = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [RANK_W-1:0] rank;
  } slot_ent_t;

  typedef struct packed {
    res_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic [ARG_W-1:0]  arg;
    logic [REM_W-1:0]  rem;
    logic              last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_load_t;

endpackage

`default_nettype wire

@@ design/dteq_req_if.sv @@
`default_nettype none

interface dteq_req_if;
  import dteq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         req_type;
  logic [SLOT_W-1:0]         slot_id;
  logic signed [DELAY_W-1:0] delay_ticks;
  logic [ARG_W-1:0]          event_arg;

  modport source (output valid, output req_type, output slot_id, output delay_ticks,
                  output event_arg, input ready);
  modport sink (input valid, input req_type, input slot_id, input delay_ticks,
                input event_arg, output ready);
endinterface

`default_nettype wire

@@ design/dteq_res_if.sv @@
`default_nettype none

interface dteq_res_if;
  import dteq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [SLOT_W-1:0] result_slot;
  logic [ARG_W-1:0]  fired_arg;
  logic [REM_W-1:0]  remaining_ticks;
  logic              last_result;

  modport source (output valid, output result_kind, output result_slot, output fired_arg,
                  output remaining_ticks, output last_result, input ready);
  modport sink (input valid, input result_kind, input result_slot, input fired_arg,
                input remaining_ticks, input last_result, output ready);
endinterface

`default_nettype wire

@@ design/dteq_out_reg.sv @@
`default_nettype none

module dteq_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  dteq_pkg::res_load_t load_i,
  output logic                free_o,
  dteq_res_if.source          out_res
);
  import dteq_pkg::*;

  logic valid_r;
  res_t data_r;

  assign free_o = !valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i.valid) begin
      valid_r <= 1'b1;
    end else if (out_res.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i.valid) begin
      data_r <= load_i.res;
    end
  end

  assign out_res.valid           = valid_r;
  assign out_res.result_kind     = data_r.kind;
  assign out_res.result_slot     = data_r.slot;
  assign out_res.fired_arg       = data_r.arg;
  assign out_res.remaining_ticks = data_r.rem;
  assign out_res.last_result     = data_r.last;

endmodule

`default_nettype wire

@@ design/delta_timer_event_queue.sv @@
// Timer queue of 16 slots kept in deadline order, one request at a time. Each request gives
// one result, except a tick, which gives one fired result per expired slot (in deadline
// order, equal deadlines in insertion order) or a single done result; last_result marks the
// final one. Slot state lives in two one-port-read memories and is walked one entry per
// cycle: query, rearm to the same time and requests that leave the queue alone skip the
// walk; arm, disarm and rearm that move a slot take one walk of the slot memory; a tick takes
// a decrement walk and, if any slot expires, a rank fix-up walk, then an argument read per
// fired slot. Only the state, a walk flag, the active marks and the result valid are cleared
// by reset, so the block takes requests straight away.
`default_nettype none

module delta_timer_event_queue (
  input  logic       clk,
  input  logic       rst_n,
  dteq_req_if.sink   in_req,
  dteq_res_if.source out_res
);
  import dteq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP,
    ST_PLACE,
    ST_TSCAN,
    ST_TFIX,
    ST_FRD,
    ST_FOUT,
    ST_SEND
  } state_t;

  state_t               state_r, state_nxt;
  logic [TYPE_W-1:0]    type_r, type_nxt;
  logic [SLOT_W-1:0]    id_r, id_nxt;
  logic [DELAY_W-1:0]   delay_r, delay_nxt;
  logic [ARG_W-1:0]     arg_r, arg_nxt;
  logic [NUM_SLOTS-1:0] armed_r, armed_nxt;
  logic [NUM_SLOTS-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pv_r, pv_nxt;
  logic [SLOT_W-1:0]    pidx_r, pidx_nxt;
  logic [RANK_W-1:0]    r0_r, r0_nxt;
  logic                 unlink_r, unlink_nxt;
  logic                 link_r, link_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]    fj_r, fj_nxt;
  logic [SLOT_W-1:0]    fire_tab_r [NUM_SLOTS];
  logic [SLOT_W-1:0]    fire_tab_nxt [NUM_SLOTS];
  res_t                 pend_r, pend_nxt;

  slot_ent_t            mem_a [NUM_SLOTS];
  logic [ARG_W-1:0]     mem_b [NUM_SLOTS];
  slot_ent_t            rd_a_r;
  logic [ARG_W-1:0]     rd_b_r;
  logic [SLOT_W-1:0]    ra_a, ra_b, wa_a;
  logic                 we_a, we_b;
  slot_ent_t            wd_a;

  res_load_t            res_load;
  logic                 out_free;
  logic                 accept;
  logic                 positive;
  logic                 s_armed;
  logic                 sweep_end;
  logic [RANK_W-1:0]    rk_dec;
  logic [SLOT_W-1:0]    fire_slot;

  dteq_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (res_load),
    .free_o  (out_free),
    .out_res (out_res)
  );

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign positive     = (delay_r != '0) && !delay_r[DELAY_W-1];
  assign s_armed      = armed_r[id_r];
  assign sweep_end    = pv_r && (pidx_r == SLOT_W'(NUM_SLOTS - 1));
  assign fire_slot    = fire_tab_r[fj_r];
  assign rk_dec       = rd_a_r.rank - RANK_W'(unlink_r && (rd_a_r.rank > r0_r));

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    rd_a_r <= mem_a[ra_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[id_r] <= arg_r;
    end
    rd_b_r <= mem_b[ra_b];
  end

  always_comb begin
    state_nxt    = state_r;
    type_nxt     = type_r;
    id_nxt       = id_r;
    delay_nxt    = delay_r;
    arg_nxt      = arg_r;
    armed_nxt    = armed_r;
    exp_nxt      = exp_r;
    idx_nxt      = idx_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    r0_nxt       = r0_r;
    unlink_nxt   = unlink_r;
    link_nxt     = link_r;
    cnt_nxt      = cnt_r;
    fj_nxt       = fj_r;
    fire_tab_nxt = fire_tab_r;
    pend_nxt     = pend_r;
    ra_a         = id_r;
    ra_b         = id_r;
    we_a         = 1'b0;
    wa_a         = pidx_r;
    wd_a         = rd_a_r;
    we_b         = 1'b0;
    res_load     = '0;

    if (state_r == ST_SWEEP || state_r == ST_TSCAN || state_r == ST_TFIX) begin
      ra_a     = idx_r[SLOT_W-1:0];
      idx_nxt  = idx_r + CNT_W'(!idx_r[CNT_W-1]);
      pv_nxt   = !idx_r[CNT_W-1];
      pidx_nxt = idx_r[SLOT_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        ra_a = in_req.slot_id;
        ra_b = in_req.slot_id;
        if (accept) begin
          type_nxt  = in_req.req_type;
          id_nxt    = in_req.slot_id;
          delay_nxt = $unsigned(in_req.delay_ticks);
          arg_nxt   = in_req.event_arg;
          exp_nxt   = '0;
          cnt_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = (in_req.req_type == REQ_TICK) ? ST_TSCAN : ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        pend_nxt.kind = RES_DONE;
        pend_nxt.slot = id_r;
        pend_nxt.arg  = '0;
        pend_nxt.rem  = '0;
        pend_nxt.last = 1'b1;
        r0_nxt        = rd_a_r.rank;
        unlink_nxt    = s_armed;
        link_nxt      = 1'b0;
        idx_nxt       = '0;
        cnt_nxt       = '0;
        state_nxt     = ST_SEND;
        case (req_type_t'(type_r))
          REQ_ARM: begin
            we_b     = 1'b1;
            link_nxt = positive;
            if (!positive) begin
              pend_nxt.kind = RES_FIRED;
              pend_nxt.arg  = arg_r;
            end
            if (s_armed || positive) begin
              state_nxt = ST_SWEEP;
            end
          end
          REQ_DISARM: begin
            if (s_armed) begin
              state_nxt = ST_SWEEP;
            end
          end
          REQ_QUERY: begin
            pend_nxt.kind = RES_QUERY;
            pend_nxt.rem  = s_armed ? rd_a_r.rem : '0;
          end
          REQ_REARM: begin
            if (!s_armed) begin
              pend_nxt.kind = RES_NOT_ARMED;
            end else if (!(positive && delay_r[REM_W-1:0] == rd_a_r.rem)) begin
              link_nxt  = positive;
              state_nxt = ST_SWEEP;
              if (!positive) begin
                pend_nxt.kind = RES_FIRED;
                pend_nxt.arg  = rd_b_r;
              end
            end
          end
          default: begin
          end
        endcase
      end

      ST_SWEEP: begin
        if (pv_r && armed_r[pidx_r] && pidx_r != id_r) begin
          we_a         = 1'b1;
          wd_a.rem     = rd_a_r.rem;
          wd_a.rank    = rk_dec;
          if (link_r) begin
            if (rd_a_r.rem > delay_r[REM_W-1:0]) begin
              wd_a.rank = rk_dec + RANK_W'(1);
            end else begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        end
        if (sweep_end) begin
          state_nxt = ST_PLACE;
        end
      end

      ST_PLACE: begin
        wa_a = id_r;
        if (link_r) begin
          we_a            = 1'b1;
          wd_a.rem        = delay_r[REM_W-1:0];
          wd_a.rank       = cnt_r[RANK_W-1:0];
          armed_nxt[id_r] = 1'b1;
        end else begin
          armed_nxt[id_r] = 1'b0;
        end
        state_nxt = ST_SEND;
      end

      ST_TSCAN: begin
        if (pv_r && armed_r[pidx_r]) begin
          we_a     = 1'b1;
          wd_a.rem = rd_a_r.rem - REM_W'(rd_a_r.rem != '0);
          if (rd_a_r.rem == REM_W'(1)) begin
            exp_nxt[pidx_r]            = 1'b1;
            fire_tab_nxt[rd_a_r.rank]  = pidx_r;
            cnt_nxt                    = cnt_r + CNT_W'(1);
          end
        end
        if (sweep_end) begin
          if (cnt_nxt == '0) begin
            pend_nxt.kind = RES_DONE;
            pend_nxt.slot = '0;
            pend_nxt.arg  = '0;
            pend_nxt.rem  = '0;
            pend_nxt.last = 1'b1;
            state_nxt     = ST_SEND;
          end else begin
            idx_nxt   = '0;
            pv_nxt    = 1'b0;
            state_nxt = ST_TFIX;
          end
        end
      end

      ST_TFIX: begin
        if (pv_r && armed_r[pidx_r] && !exp_r[pidx_r]) begin
          we_a      = 1'b1;
          wd_a.rank = rd_a_r.rank - cnt_r[RANK_W-1:0];
        end
        if (sweep_end) begin
          armed_nxt = armed_r & ~exp_r;
          fj_nxt    = '0;
          state_nxt = ST_FRD;
        end
      end

      ST_FRD: begin
        ra_b      = fire_slot;
        state_nxt = ST_FOUT;
      end

      ST_FOUT: begin
        ra_b = fire_slot;
        if (out_free) begin
          res_load.valid    = 1'b1;
          res_load.res.kind = RES_FIRED;
          res_load.res.slot = fire_slot;
          res_load.res.arg  = rd_b_r;
          res_load.res.rem  = '0;
          res_load.res.last = ({1'b0, fj_r} == cnt_r - CNT_W'(1));
          if (res_load.res.last) begin
            state_nxt = ST_IDLE;
          end else begin
            fj_nxt    = fj_r + SLOT_W'(1);
            state_nxt = ST_FRD;
          end
        end
      end

      ST_SEND: begin
        if (out_free) begin
          res_load.valid = 1'b1;
          res_load.res   = pend_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      armed_r <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      armed_r <= armed_nxt;
      pv_r    <= pv_nxt;
    end
    type_r     <= type_nxt;
    id_r       <= id_nxt;
    delay_r    <= delay_nxt;
    arg_r      <= arg_nxt;
    exp_r      <= exp_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    r0_r       <= r0_nxt;
    unlink_r   <= unlink_nxt;
    link_r     <= link_nxt;
    cnt_r      <= cnt_nxt;
    fj_r       <= fj_nxt;
    fire_tab_r <= fire_tab_nxt;
    pend_r     <= pend_nxt;
  end

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_req.ready)
    else $error("request taken while another is in progress");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load.valid |-> out_free)
    else $error("result loaded over an untaken result");

  a_fire_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOUT) |-> (cnt_r != '0 && {1'b0, fj_r} < cnt_r))
    else $error("fire index beyond expired count");

  a_link_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE && link_r) |-> (cnt_r <= $countones(armed_r)))
    else $error("queue position beyond armed slots");

endmodule

`default_nettype wire

@@ test/delta_timer_event_queue_test.sv @@
`default_nettype none

module delta_timer_event_queue_test;
  import dteq_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [TYPE_W-1:0] REQ_RESERVED_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_RESERVED_HI = 3'd7;
  localparam logic [DELAY_W-1:0] DELAY_MIN = 32'h8000_0000;
  localparam logic [DELAY_W-1:0] DELAY_MAX = 32'h7fff_ffff;

  logic clk = 1'b0;
  logic rst_n;

  dteq_req_if in_req();
  dteq_res_if out_res();

  delta_timer_event_queue dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #1 clk = ~clk;

  // timer slot state as the block should hold it
  logic [DELAY_W-1:0] slot_left [NUM_SLOTS];
  logic [ARG_W-1:0]   slot_word [NUM_SLOTS];
  bit                 slot_on   [NUM_SLOTS];
  int unsigned        slot_pos  [NUM_SLOTS];

  res_t awaited_results[$];
  int   mismatches = 0;
  int   reqs_sent = 0;
  int   cycle_count = 0;
  bit   steady = 1'b0;
  int   hold_request = 0;

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_result(res_kind_t kind, logic [SLOT_W-1:0] slot,
                                     logic [ARG_W-1:0] arg, logic [REM_W-1:0] rem,
                                     logic last);
    res_t r;
    r.kind = kind;
    r.slot = slot;
    r.arg  = arg;
    r.rem  = rem;
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void drop_slot(int s);
    if (!slot_on[s]) return;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_on[i] && slot_pos[i] > slot_pos[s]) slot_pos[i]--;
    slot_on[s] = 1'b0;
  endfunction

  // queue behind every slot whose deadline is not later
  function automatic void queue_slot(int s, logic [DELAY_W-1:0] ticks);
    int unsigned place;
    place = 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_on[i] && slot_left[i] <= ticks) place++;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_on[i] && slot_pos[i] >= place) slot_pos[i]++;
    slot_left[s] = ticks;
    slot_pos[s]  = place;
    slot_on[s]   = 1'b1;
  endfunction

  function automatic void predict_timer_results(logic [TYPE_W-1:0] kind,
                                                logic [SLOT_W-1:0] slot,
                                                logic [DELAY_W-1:0] delay,
                                                logic [ARG_W-1:0] arg);
    bit later;
    int s;
    int head;
    int fired;
    later = (delay != 0) && !delay[DELAY_W-1];
    s = slot;
    case (kind)
      REQ_ARM: begin
        drop_slot(s);
        slot_word[s] = arg;
        if (!later) begin
          add_result(RES_FIRED, slot, arg, '0, 1'b1);
        end else begin
          queue_slot(s, delay);
          add_result(RES_DONE, slot, '0, '0, 1'b1);
        end
      end
      REQ_DISARM: begin
        drop_slot(s);
        add_result(RES_DONE, slot, '0, '0, 1'b1);
      end
      REQ_QUERY: begin
        add_result(RES_QUERY, slot, '0, slot_on[s] ? slot_left[s][REM_W-1:0] : '0, 1'b1);
      end
      REQ_REARM: begin
        if (!slot_on[s]) begin
          add_result(RES_NOT_ARMED, slot, '0, '0, 1'b1);
        end else if (later && delay == slot_left[s]) begin
          add_result(RES_DONE, slot, '0, '0, 1'b1);
        end else begin
          drop_slot(s);
          if (!later) begin
            add_result(RES_FIRED, slot, slot_word[s], '0, 1'b1);
          end else begin
            queue_slot(s, delay);
            add_result(RES_DONE, slot, '0, '0, 1'b1);
          end
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (slot_on[i] && slot_left[i] > 0) slot_left[i]--;
        fired = 0;
        while (fired < NUM_SLOTS) begin
          head = -1;
          for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_on[i] && slot_pos[i] == 0) head = i;
          if (head < 0) break;
          if (slot_left[head] != 0) break;
          add_result(RES_FIRED, SLOT_W'(head), slot_word[head], '0, 1'b0);
          fired++;
          drop_slot(head);
        end
        if (fired == 0) add_result(RES_DONE, '0, '0, '0, 1'b1);
        else awaited_results[awaited_results.size()-1].last = 1'b1;
      end
      default: begin
        add_result(RES_DONE, slot, '0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                          input logic [DELAY_W-1:0] delay, input logic [ARG_W-1:0] arg);
    int gap;
    gap = steady ? 0 : pause_len();
    repeat (gap + 1) @(negedge clk);
    in_req.valid       <= 1'b1;
    in_req.req_type    <= kind;
    in_req.slot_id     <= slot;
    in_req.delay_ticks <= delay;
    in_req.event_arg   <= arg;
    do @(posedge clk); while (!in_req.ready);
    predict_timer_results(kind, slot, delay, arg);
    reqs_sent++;
    @(negedge clk);
    in_req.valid <= 1'b0;
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(1, 8);
    if (r < 65) return $urandom_range(9, 40);
    if (r < 72) return '0;
    if (r < 80) return {1'b1, 31'($urandom)};
    if (r < 83) return DELAY_MIN;
    if (r < 93) return {1'b0, 31'($urandom)};
    return DELAY_MAX;
  endfunction

  task automatic send_random_item();
    int r;
    logic [SLOT_W-1:0]  s;
    logic [DELAY_W-1:0] d;
    logic [TYPE_W-1:0]  k;
    r = $urandom_range(0, 99);
    s = SLOT_W'($urandom);
    d = pick_delay();
    if (r < 30) k = REQ_ARM;
    else if (r < 60) k = REQ_TICK;
    else if (r < 72) k = REQ_QUERY;
    else if (r < 80) k = REQ_DISARM;
    else if (r < 95) begin
      k = REQ_REARM;
      if (slot_on[s] && $urandom_range(0, 2) == 0) d = slot_left[s];
    end else begin
      k = TYPE_W'($urandom_range(REQ_RESERVED_LO, REQ_RESERVED_HI));
    end
    send_req(k, s, d, $urandom);
  endtask

  // fill every slot with one deadline, then tick until all fire together
  task automatic send_arm_burst();
    int first;
    int d;
    first = $urandom_range(0, NUM_SLOTS - 1);
    d = $urandom_range(1, 3);
    for (int i = 0; i < NUM_SLOTS; i++)
      send_req(REQ_ARM, SLOT_W'(first + i), DELAY_W'(d), $urandom);
    repeat (d) send_req(REQ_TICK, SLOT_W'($urandom), pick_delay(), $urandom);
  endtask

  task automatic test_unarmed_requests();
    send_req(REQ_QUERY, 4'd0, 32'd7, 32'd0);
    send_req(REQ_REARM, 4'd5, 32'd3, 32'hffff_ffff);
    send_req(REQ_DISARM, 4'd3, 32'd0, 32'd0);
    send_req(REQ_TICK, 4'd9, DELAY_MAX, 32'hffff_ffff);
    for (int k = REQ_RESERVED_LO; k <= REQ_RESERVED_HI; k++)
      send_req(TYPE_W'(k), 4'd12, DELAY_MIN, 32'h5a5a_5a5a);
  endtask

  task automatic test_immediate_fire();
    send_req(REQ_ARM, 4'd15, 32'd0, 32'hffff_ffff);
    send_req(REQ_ARM, 4'd1, DELAY_MIN, 32'h0000_0001);
    send_req(REQ_ARM, 4'd7, 32'hffff_ffff, 32'h8000_0000);
    send_req(REQ_ARM, 4'd8, 32'd3, 32'h1234_5678);
    send_req(REQ_REARM, 4'd8, 32'd0, 32'hdead_beef);
    send_req(REQ_QUERY, 4'd8, 32'd0, 32'd0);
  endtask

  task automatic test_query_extremes();
    send_req(REQ_ARM, 4'd2, DELAY_MAX, 32'd0);
    send_req(REQ_QUERY, 4'd2, 32'd0, 32'd0);
    send_req(REQ_DISARM, 4'd2, 32'd0, 32'd0);
    send_req(REQ_QUERY, 4'd2, 32'd0, 32'd0);
  endtask

  task automatic test_equal_deadlines();
    send_req(REQ_ARM, 4'd3, 32'd2, 32'ha5a5_a5a5);
    send_req(REQ_ARM, 4'd4, 32'd2, 32'h0f0f_0f0f);
    send_req(REQ_ARM, 4'd5, 32'd1, 32'hf0f0_f0f0);
    send_req(REQ_REARM, 4'd3, 32'd2, 32'd0);
    send_req(REQ_TICK, 4'd0, 32'd0, 32'd0);
    send_req(REQ_TICK, 4'd0, 32'd0, 32'd0);
  endtask

  task automatic test_random(input int count, input bit gapless);
    int target;
    target = reqs_sent + count;
    steady = gapless;
    send_arm_burst();
    while (reqs_sent < target) begin
      if ($urandom_range(0, 99) < 3) send_arm_burst();
      else send_random_item();
    end
    steady = 1'b0;
  endtask

  // hold the result side off while requests keep coming
  task automatic test_input_stall();
    steady = 1'b1;
    hold_request = 400;
    repeat (20) send_random_item();
    steady = 1'b0;
    wait (awaited_results.size() == 0);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: kind %0d slot %0d, expected nothing", $time,
                 out_res.result_kind, out_res.result_slot);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("result_kind", want.kind, out_res.result_kind);
        check_field("result_slot", want.slot, out_res.result_slot);
        check_field("fired_arg", want.arg, out_res.fired_arg);
        check_field("remaining_ticks", want.rem, out_res.remaining_ticks);
        check_field("last_result", want.last, out_res.last_result);
      end
    end
  end

  initial begin
    int hold_left;
    int ready_wait;
    hold_left = 0;
    ready_wait = 0;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_res.ready <= 1'b0;
        hold_left--;
      end else if (ready_wait > 0) begin
        out_res.ready <= 1'b0;
        ready_wait--;
      end else begin
        out_res.ready <= 1'b1;
        if (!steady) ready_wait = pause_len();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("delta_timer_event_queue_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.req_type = '0;
    in_req.slot_id = '0;
    in_req.delay_ticks = '0;
    in_req.event_arg = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_left[i] = '0;
      slot_word[i] = '0;
      slot_on[i]   = 1'b0;
      slot_pos[i]  = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unarmed_requests();
    test_immediate_fire();
    test_query_extremes();
    test_equal_deadlines();
    test_random(125, 1'b0);
    test_input_stall();
    test_random(120, 1'b1);
    test_random(125, 1'b0);

    wait (awaited_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("delta_timer_event_queue_test OK");
    end else begin
      $display("delta_timer_event_queue_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/dteq_pkg.sv
design/dteq_req_if.sv
design/dteq_res_if.sv
design/dteq_out_reg.sv
design/delta_timer_event_queue.sv
test/delta_timer_event_queue_test.sv
